// ===== design/bat_pkg.sv =====
package bat_pkg;

  localparam int NUM_BUTTONS = 32;
  localparam int MASK_W      = 32;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [MASK_W-1:0] ALL_ONES    = '1;
  localparam logic [MASK_W-1:0] BUTTON_MASK = ALL_ONES >> (MASK_W - NUM_BUTTONS);

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RELOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST  = 1'd1;

  typedef struct packed {
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] first;
  } bat_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] held;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] rpt;
  } bat_masks_t;

endpackage

// ===== design/bat_lane.sv =====
module bat_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              held,
  input  bat_pkg::bat_cfg_t cfg,
  output logic              hit
);
  import bat_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W:0]   inc;
  logic [CNT_W:0]   cand;

  always_comb begin
    inc     = held ? ({1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1}) : '0;
    cand    = (inc == {1'b0, cfg.first}) ? {1'b0, cfg.reload} : inc;
    hit     = (cand == {1'b0, cfg.reload});
    cnt_nxt = upd ? cand[CNT_W-1:0] : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/bat_merge.sv =====
module bat_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        op,
  input  logic [bat_pkg::MASK_W-1:0]  sample,
  input  logic [bat_pkg::MASK_W-1:0]  hits,
  output bat_pkg::bat_masks_t         cur,
  output bat_pkg::bat_masks_t         result
);
  import bat_pkg::*;

  bat_masks_t        sticky_r;
  bat_masks_t        sticky_nxt;
  bat_masks_t        upd;
  logic [MASK_W-1:0] prev_r;
  logic [MASK_W-1:0] prev_nxt;
  logic              gate_r;
  logic              gate_nxt;
  logic [MASK_W-1:0] chg;

  assign cur = sticky_r;

  always_comb begin
    chg          = (prev_r ^ sample) & BUTTON_MASK;
    upd.held     = sticky_r.held | sample;
    upd.pressed  = sticky_r.pressed | (chg & sample);
    upd.released = (sticky_r.released | (chg & prev_r)) & {MASK_W{gate_r}};
    upd.rpt      = sticky_r.rpt | hits;
    result       = (op == OP_SNAPSHOT) ? sticky_r : upd;

    sticky_nxt = sticky_r;
    prev_nxt   = prev_r;
    gate_nxt   = gate_r;
    if (accept) begin
      if (op == OP_SNAPSHOT) begin
        sticky_nxt = '0;
      end else begin
        sticky_nxt = upd;
        prev_nxt   = sample;
        gate_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r <= '0;
      prev_r   <= ALL_ONES;
      gate_r   <= 1'b0;
    end else begin
      sticky_r <= sticky_nxt;
      prev_r   <= prev_nxt;
      gate_r   <= gate_nxt;
    end
  end

endmodule

// ===== design/button_autorepeat_tracker_unit.sv =====
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_op, in_buttons
// out      out_valid / out_ready    out_held_mask, out_pressed_mask,
//                                   out_released_mask, out_repeat_mask
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request per cycle while in_ready is high; each result is registered.
// Lanes update on accepted sample requests, the merge on every accept.
// Synchronous active-low reset clears counters, sticky masks, valid flags.
// A two-deep output buffer (output register plus skid) takes a request
// while a result waits; in_ready drops only when both entries are full.
module button_autorepeat_tracker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [31:0]                   in_buttons,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_held_mask,
  output logic [31:0]                   out_pressed_mask,
  output logic [31:0]                   out_released_mask,
  output logic [31:0]                   out_repeat_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bat_pkg::CNT_W-1:0]     cfg_data
);
  import bat_pkg::*;

  bat_cfg_t          cfg_r;
  bat_cfg_t          cfg_nxt;
  logic              in_acc;
  logic              upd_lanes;
  logic [MASK_W-1:0] sample;
  logic [MASK_W-1:0] hits;
  bat_masks_t        cur;
  bat_masks_t        res;
  bat_masks_t        out_r;
  bat_masks_t        out_nxt;
  bat_masks_t        skid_r;
  bat_masks_t        skid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  logic              take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign upd_lanes = in_acc && (in_op == OP_SAMPLE);
  assign sample    = in_buttons & BUTTON_MASK;
  assign take      = out_valid_r && out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPEAT_RELOAD: cfg_nxt.reload = cfg_data;
        REG_REPEAT_FIRST:  cfg_nxt.first  = cfg_data;
        default:           cfg_nxt        = cfg_r;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < MASK_W; g++) begin : g_lane
      if (g < NUM_BUTTONS) begin : g_used
        bat_lane u_lane (
          .clk   (clk),
          .rst_n (rst_n),
          .upd   (upd_lanes),
          .held  (sample[g]),
          .cfg   (cfg_r),
          .hit   (hits[g])
        );
      end else begin : g_unused
        assign hits[g] = 1'b0;
      end
    end
  endgenerate

  bat_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .op     (in_op),
    .sample (sample),
    .hits   (hits),
    .cur    (cur),
    .result (res)
  );

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_held_mask     = out_r.held;
  assign out_pressed_mask  = out_r.pressed;
  assign out_released_mask = out_r.released;
  assign out_repeat_mask   = out_r.rpt;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request left no result");

  a_snapshot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_SNAPSHOT)) |=> (cur == '0))
    else $error("sticky masks not cleared after snapshot");

  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_REPEAT_RELOAD))
      |=> (cfg_r.reload == $past(cfg_data)))
    else $error("repeat reload register not written");

endmodule
